// ----- hdl/cbpe_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbpe_pkg
// Shared widths, register indexes, pipeline control type and the rounded
// Q0.30 multiply used by the cubic Bezier point evaluator.
// ----------------------------------------------------------------------------
package cbpe_pkg;

    localparam int COORD_BITS  = 16;
    localparam int T_FRAC_BITS = 16;
    localparam int CUBIC       = 4;
    localparam int WBITS       = 30;

    // parameter t, unsigned Q0.T_FRAC_BITS plus the bit for 1.0
    localparam int T_W    = T_FRAC_BITS + 1;
    // Q0.30 values up to and including 1.0
    localparam int WQ     = WBITS + 1;
    // Bernstein weight after the factor of three
    localparam int WW     = WQ + 1;
    // weight times coordinate, signed
    localparam int PROD_W = WW + 1 + COORD_BITS;
    localparam int PAIR_W = PROD_W + 1;
    localparam int ACC_W  = PROD_W + 2;
    localparam int SH_W   = ACC_W - WBITS;

    localparam int NREGS     = 2 * CUBIC;
    localparam int CFG_ADDR_W = 4;
    localparam int IN_TDATA_W  = ((T_W + 7) / 8) * 8;
    localparam int OUT_TDATA_W = ((2 * COORD_BITS + 7) / 8) * 8;

    localparam logic [CFG_ADDR_W-1:0] REG_P0_X = CFG_ADDR_W'(0);
    localparam logic [CFG_ADDR_W-1:0] REG_P0_Y = CFG_ADDR_W'(1);
    localparam logic [CFG_ADDR_W-1:0] REG_P1_X = CFG_ADDR_W'(2);
    localparam logic [CFG_ADDR_W-1:0] REG_P1_Y = CFG_ADDR_W'(3);
    localparam logic [CFG_ADDR_W-1:0] REG_P2_X = CFG_ADDR_W'(4);
    localparam logic [CFG_ADDR_W-1:0] REG_P2_Y = CFG_ADDR_W'(5);
    localparam logic [CFG_ADDR_W-1:0] REG_P3_X = CFG_ADDR_W'(6);
    localparam logic [CFG_ADDR_W-1:0] REG_P3_Y = CFG_ADDR_W'(7);

    typedef logic [T_W-1:0]                      param_t;
    typedef logic [WQ-1:0]                       q_t;
    typedef logic [CUBIC-1:0][WW-1:0]            weight_vec_t;
    typedef logic [COORD_BITS-1:0]               coord_t;
    typedef logic [CUBIC-1:0][COORD_BITS-1:0]    coord_vec_t;

    // load enables of the six pipeline stages
    typedef struct packed {
        logic en_tq;
        logic en_sq;
        logic en_cube;
        logic en_prod;
        logic en_pair;
        logic en_out;
    } stage_en_t;

    // (a * b + 2^(WBITS-1)) >> WBITS
    function automatic q_t wmul(input q_t a, input q_t b);
        logic [2*WQ-1:0] half;
        logic [2*WQ-1:0] prod;
        half = '0;
        half[WBITS-1] = 1'b1;
        prod = {{WQ{1'b0}}, a} * {{WQ{1'b0}}, b} + half;
        return prod[WBITS +: WQ];
    endfunction

endpackage

// ----- hdl/cbpe_weights.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbpe_weights
// Three stages that turn the curve parameter into the four Bernstein
// weights: saturate and align t, then squares and the cross term, then
// the cubic terms.
// ----------------------------------------------------------------------------
module cbpe_weights (
    input  logic                clk,
    input  cbpe_pkg::stage_en_t ctl,
    input  cbpe_pkg::param_t    param_t_in,
    output cbpe_pkg::weight_vec_t weights
);
    import cbpe_pkg::*;

    localparam param_t ONE_T = T_W'(1) << T_FRAC_BITS;
    localparam q_t     ONE_Q = WQ'(1) << WBITS;

    param_t t_sat;
    q_t     tq_next;

    q_t tq_reg;
    q_t uq_reg;

    q_t tq1_reg;
    q_t t2_reg;
    q_t u2_reg;
    q_t tu_reg;
    q_t uq1_reg;

    q_t t3_reg;
    q_t u3_reg;
    q_t a_reg;
    q_t b_reg;

    always_comb
    begin
        t_sat   = (param_t_in > ONE_T) ? ONE_T : param_t_in;
        tq_next = {t_sat, {(WBITS - T_FRAC_BITS){1'b0}}};
    end

    always_ff @(posedge clk)
    begin
        if (ctl.en_tq)
        begin
            tq_reg <= tq_next;
            uq_reg <= ONE_Q - tq_next;
        end
        if (ctl.en_sq)
        begin
            tq1_reg <= tq_reg;
            uq1_reg <= uq_reg;
            t2_reg  <= wmul(tq_reg, tq_reg);
            u2_reg  <= wmul(uq_reg, uq_reg);
            tu_reg  <= wmul(tq_reg, uq_reg);
        end
        if (ctl.en_cube)
        begin
            t3_reg <= wmul(t2_reg, tq1_reg);
            u3_reg <= wmul(u2_reg, uq1_reg);
            a_reg  <= wmul(tu_reg, uq1_reg);
            b_reg  <= wmul(tu_reg, tq1_reg);
        end
    end

    // times three as shift and add
    always_comb
    begin
        weights[0] = WW'(u3_reg);
        weights[1] = WW'(a_reg) + (WW'(a_reg) << 1);
        weights[2] = WW'(b_reg) + (WW'(b_reg) << 1);
        weights[3] = WW'(t3_reg);
    end

endmodule

// ----- hdl/cbpe_axis.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbpe_axis
// Weighted sum for one coordinate axis: four products, two pair sums,
// then the final sum with round half up and clamp to the coordinate range.
// ----------------------------------------------------------------------------
module cbpe_axis (
    input  logic                  clk,
    input  cbpe_pkg::stage_en_t   ctl,
    input  cbpe_pkg::weight_vec_t weights,
    input  cbpe_pkg::coord_vec_t  coords,
    output cbpe_pkg::coord_t      point
);
    import cbpe_pkg::*;

    logic signed [PROD_W-1:0] prod_reg [CUBIC];
    logic signed [PAIR_W-1:0] pair_lo_reg;
    logic signed [PAIR_W-1:0] pair_hi_reg;
    coord_t                   point_reg;

    logic signed [PROD_W-1:0] prod_next [CUBIC];
    logic signed [ACC_W-1:0]  acc;
    logic signed [ACC_W-1:0]  half;
    logic signed [ACC_W-1:0]  rnd;
    logic [SH_W-1:0]          sh;
    logic [SH_W-COORD_BITS:0] top_bits;
    coord_t                   point_next;

    always_comb
    begin
        for (int i = 0; i < CUBIC; i++)
        begin
            prod_next[i] = $signed({1'b0, weights[i]}) * $signed(coords[i]);
        end
    end

    always_comb
    begin
        half = '0;
        half[WBITS-1] = 1'b1;
        acc = ACC_W'(pair_lo_reg) + ACC_W'(pair_hi_reg);
        rnd = acc + half;
        // floor of the rounded sum: drop the fraction bits
        sh = rnd[ACC_W-1:WBITS];
        top_bits = sh[SH_W-1:COORD_BITS-1];
        if (top_bits == '0 || top_bits == '1)
        begin
            point_next = sh[COORD_BITS-1:0];
        end
        else if (sh[SH_W-1])
        begin
            point_next = {1'b1, {(COORD_BITS-1){1'b0}}};
        end
        else
        begin
            point_next = {1'b0, {(COORD_BITS-1){1'b1}}};
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.en_prod)
        begin
            for (int i = 0; i < CUBIC; i++)
            begin
                prod_reg[i] <= prod_next[i];
            end
        end
        if (ctl.en_pair)
        begin
            pair_lo_reg <= PAIR_W'(prod_reg[0]) + PAIR_W'(prod_reg[1]);
            pair_hi_reg <= PAIR_W'(prod_reg[2]) + PAIR_W'(prod_reg[3]);
        end
        if (ctl.en_out)
        begin
            point_reg <= point_next;
        end
    end

    assign point = point_reg;

endmodule

// ----- hdl/cubic_bezier_point_eval.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cubic_bezier_point_eval
// Evaluates a 2-D cubic Bezier curve at one parameter t per request.
//
//   Channel   Direction  Payload (low bit up)
//   s_axis    in         tdata: param_t[16:0], zero fill to 24 bits
//   m_axis    out        tdata: point_x[15:0], point_y[31:16]
//   cfg       in         cfg_addr selects p0_x..p3_y, cfg_data is the value
//
// Six register stages; m_tvalid rises once a request has loaded into the last
// stage, and one request is taken every cycle unless m_tready low holds a
// full pipeline back.
// Each stage holds while its successor is full and stalled, so bubbles
// collapse and nothing is lost or repeated under back-pressure.
// Reset clears the valid bits and the control point registers to zero.
// ----------------------------------------------------------------------------
module cubic_bezier_point_eval (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [cbpe_pkg::IN_TDATA_W-1:0]    s_tdata,   // param_t
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [cbpe_pkg::OUT_TDATA_W-1:0]   m_tdata,   // point_x, point_y
    input  logic                               cfg_we,
    input  logic [cbpe_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  logic [cbpe_pkg::COORD_BITS-1:0]    cfg_data
);
    import cbpe_pkg::*;

    localparam int NSTAGES = 6;

    coord_t ctrl_reg [NREGS];

    logic [NSTAGES-1:0] valid_reg;
    logic [NSTAGES-1:0] valid_next;
    logic [NSTAGES-1:0] en;
    stage_en_t          ctl;

    weight_vec_t weights;
    coord_vec_t  coords_x;
    coord_vec_t  coords_y;
    coord_t      point_x;
    coord_t      point_y;

    // a stage loads when it is empty or its successor loads
    always_comb
    begin
        en[NSTAGES-1] = !valid_reg[NSTAGES-1] || m_tready;
        for (int k = NSTAGES - 2; k >= 0; k--)
        begin
            en[k] = !valid_reg[k] || en[k+1];
        end
        valid_next[0] = en[0] ? s_tvalid : valid_reg[0];
        for (int k = 1; k < NSTAGES; k++)
        begin
            valid_next[k] = en[k] ? valid_reg[k-1] : valid_reg[k];
        end
    end

    always_comb
    begin
        ctl.en_tq   = en[0];
        ctl.en_sq   = en[1];
        ctl.en_cube = en[2];
        ctl.en_prod = en[3];
        ctl.en_pair = en[4];
        ctl.en_out  = en[5];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // drop writes to indexes past the last register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NREGS; i++)
            begin
                ctrl_reg[i] <= '0;
            end
        end
        else if (cfg_we && cfg_addr <= REG_P3_Y)
        begin
            ctrl_reg[cfg_addr[$clog2(NREGS)-1:0]] <= cfg_data;
        end
    end

    always_comb
    begin
        coords_x[0] = ctrl_reg[REG_P0_X[$clog2(NREGS)-1:0]];
        coords_x[1] = ctrl_reg[REG_P1_X[$clog2(NREGS)-1:0]];
        coords_x[2] = ctrl_reg[REG_P2_X[$clog2(NREGS)-1:0]];
        coords_x[3] = ctrl_reg[REG_P3_X[$clog2(NREGS)-1:0]];
        coords_y[0] = ctrl_reg[REG_P0_Y[$clog2(NREGS)-1:0]];
        coords_y[1] = ctrl_reg[REG_P1_Y[$clog2(NREGS)-1:0]];
        coords_y[2] = ctrl_reg[REG_P2_Y[$clog2(NREGS)-1:0]];
        coords_y[3] = ctrl_reg[REG_P3_Y[$clog2(NREGS)-1:0]];
    end

    cbpe_weights u_weights (
        .clk        (clk),
        .ctl        (ctl),
        .param_t_in (s_tdata[T_W-1:0]),
        .weights    (weights)
    );

    cbpe_axis u_axis_x (
        .clk     (clk),
        .ctl     (ctl),
        .weights (weights),
        .coords  (coords_x),
        .point   (point_x)
    );

    cbpe_axis u_axis_y (
        .clk     (clk),
        .ctl     (ctl),
        .weights (weights),
        .coords  (coords_y),
        .point   (point_y)
    );

    assign s_tready = en[0];
    assign m_tvalid = valid_reg[NSTAGES-1];
    assign m_tdata  = OUT_TDATA_W'({point_y, point_x});

endmodule
